### hdl/sles_pkg.sv
// ----------------------------------------------------------------------------
// sles_pkg
// Shared types and constants of the status LED effect sequencer: controller
// states, controller/datapath command and status groups, colors, timings.
// ----------------------------------------------------------------------------
package sles_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_STARTUP_IV = 3'd0;
  localparam logic [2:0] CFG_PROFILE_IV = 3'd1;
  localparam logic [2:0] CFG_BLINKS     = 3'd2;
  localparam logic [2:0] CFG_FRAME      = 3'd3;
  localparam logic [2:0] CFG_POLICE_IV  = 3'd4;

  // Configuration reset values
  localparam logic [15:0] STARTUP_IV_RST = 16'd150;
  localparam logic [15:0] PROFILE_IV_RST = 16'd150;
  localparam logic [7:0]  BLINKS_RST     = 8'd3;
  localparam logic [15:0] FRAME_RST      = 16'd3;
  localparam logic [15:0] POLICE_IV_RST  = 16'd80;

  // Profile ids
  localparam logic [2:0] PROF_ROOKIE   = 3'd0;
  localparam logic [2:0] PROF_NORMAL   = 3'd1;
  localparam logic [2:0] PROF_ADVANCED = 3'd2;
  localparam logic [2:0] PROF_DRIFT    = 3'd3;
  localparam logic [2:0] PROF_POLICE   = 3'd4;

  // Colors, {red, green, blue}
  localparam logic [23:0] RGB_OFF    = 24'h000000;
  localparam logic [23:0] RGB_GREEN  = 24'h00FF00;
  localparam logic [23:0] RGB_BLUE   = 24'h0000FF;
  localparam logic [23:0] RGB_RED    = 24'hFF0000;
  localparam logic [23:0] RGB_ORANGE = 24'hFF5000;
  localparam logic [23:0] RGB_PURPLE = 24'hB400FF;

  // Color ramp
  localparam logic [9:0] RAMP_STEP = 10'd5;
  localparam logic [9:0] RAMP_WRAP = 10'd510;

  // Reciprocals: x/127 ~ x*129 >> 14 and x/254 ~ x*129 >> 15, both low by
  // at most one, fixed up with a single remainder compare and increment.
  localparam logic [20:0] G_RECIP = 21'd10320; // 80 * 129
  localparam logic [22:0] L_RECIP = 23'd22575; // 175 * 129

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_RAMP_EST,
    ST_RAMP_FIX,
    ST_RAMP_MUL,
    ST_RAMP_DIV,
    ST_DONE
  } sles_state_e;

  typedef struct packed {
    logic capture;
    logic eval;
    logic ramp_est;
    logic ramp_fix;
    logic ramp_mul;
    logic ramp_div;
    logic load_out;
  } sles_cmd_t;

  typedef struct packed {
    logic ramp_go;
  } sles_sts_t;

  function automatic logic [23:0] profile_rgb(input logic [2:0] prof);
    logic [23:0] rgb;
    case (prof)
      PROF_ROOKIE:   rgb = RGB_GREEN;
      PROF_NORMAL:   rgb = RGB_BLUE;
      PROF_ADVANCED: rgb = RGB_ORANGE;
      PROF_DRIFT:    rgb = RGB_PURPLE;
      PROF_POLICE:   rgb = RGB_BLUE;
      default:       rgb = RGB_OFF;
    endcase
    return rgb;
  endfunction

endpackage

### hdl/sles_ctrl.sv
// ----------------------------------------------------------------------------
// sles_ctrl
// Sequencer of the effect block: takes an input transfer, runs the effect
// update, steps the color ramp pipeline and loads the output register.
// ----------------------------------------------------------------------------
module sles_ctrl
  import sles_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  output logic      s_ready_o,
  output logic      m_valid_o,
  input  logic      m_ready_i,
  input  sles_sts_t sts_i,
  output sles_cmd_t cmd_o
);

  sles_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.ramp_go ? ST_RAMP_EST : ST_DONE;
      end
      ST_RAMP_EST: begin
        cmd_o.ramp_est = 1'b1;
        state_d        = ST_RAMP_FIX;
      end
      ST_RAMP_FIX: begin
        cmd_o.ramp_fix = 1'b1;
        state_d        = ST_RAMP_MUL;
      end
      ST_RAMP_MUL: begin
        cmd_o.ramp_mul = 1'b1;
        state_d        = ST_RAMP_DIV;
      end
      ST_RAMP_DIV: begin
        cmd_o.ramp_div = 1'b1;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        // wait until the previous result has been transferred
        if (!out_valid_q || m_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign m_valid_o = out_valid_q;

endmodule

### hdl/sles_datapath.sv
// ----------------------------------------------------------------------------
// sles_datapath
// Effect state, configuration registers, color ramp pipeline and output
// register of the status LED effect sequencer.
// ----------------------------------------------------------------------------
module sles_datapath
  import sles_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sles_cmd_t   cmd_i,
  output sles_sts_t   sts_o,
  input  logic [31:0] now_ms_i,
  input  logic [2:0]  profile_i,
  input  logic        turbo_on_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        led_write_o,
  output logic [7:0]  led_red_o,
  output logic [7:0]  led_green_o,
  output logic [7:0]  led_blue_o
);

  // x / 255 for x < 65280, where the quotient fits in eight bits
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  // Configuration
  logic [15:0] startup_iv_q, profile_iv_q, frame_q, police_iv_q;
  logic [7:0]  blinks_q;

  // Captured item
  logic [TIME_BITS-1:0] now_q;
  logic [2:0]           prof_q;
  logic                 turbo_q;

  // Effect state
  logic                 have_q, have_d;
  logic [2:0]           cur_q, cur_d;
  logic                 st_run_q, st_run_d;
  logic                 st_lit_q, st_lit_d;
  logic [1:0]           st_cnt_q, st_cnt_d;
  logic [TIME_BITS-1:0] st_last_q, st_last_d;
  logic                 ch_run_q, ch_run_d;
  logic                 ch_lit_q, ch_lit_d;
  logic [7:0]           ch_cnt_q, ch_cnt_d;
  logic [TIME_BITS-1:0] ch_last_q, ch_last_d;
  logic                 boost_q, boost_d;
  logic [8:0]           phase_q, phase_d;
  logic [TIME_BITS-1:0] ra_last_q, ra_last_d;
  logic                 si_blue_q, si_blue_d;
  logic [TIME_BITS-1:0] si_last_q, si_last_d;
  logic [23:0]          colour_q, colour_d;
  logic                 wrote_q, wrote_d;

  // Ramp pipeline
  logic [6:0]  est_g_q;
  logic [7:0]  est_l_q;
  logic [7:0]  r0_q, g0_q, b0_q, lum_q;
  logic [15:0] pr_q, pg_q, pb_q;

  // Output register
  logic        out_write_q;
  logic [23:0] out_rgb_q;

  // Values after a profile change has been applied
  logic                 chg;
  logic                 ch_lit_v, boost_v, si_blue_v;
  logic [7:0]           ch_cnt_v;
  logic [8:0]           phase_v;
  logic [TIME_BITS-1:0] ch_last_v, si_last_v;
  logic                 el_st, el_ch, el_ra, el_si;
  logic [9:0]           psum;

  assign chg       = have_q && (prof_q != cur_q);
  assign ch_lit_v  = chg ? 1'b0 : ch_lit_q;
  assign ch_cnt_v  = chg ? 8'd0 : ch_cnt_q;
  assign ch_last_v = chg ? now_q : ch_last_q;
  assign boost_v   = chg ? 1'b0 : boost_q;
  assign phase_v   = chg ? 9'd0 : phase_q;
  assign si_blue_v = chg ? 1'b0 : si_blue_q;
  assign si_last_v = chg ? '0 : si_last_q;

  // modulo-2^TIME_BITS elapsed checks
  assign el_st = TIME_BITS'(now_q - st_last_q) >= TIME_BITS'(startup_iv_q);
  assign el_ch = TIME_BITS'(now_q - ch_last_v) >= TIME_BITS'(profile_iv_q);
  assign el_ra = TIME_BITS'(now_q - ra_last_q) >= TIME_BITS'(frame_q);
  assign el_si = TIME_BITS'(now_q - si_last_v) >= TIME_BITS'(police_iv_q);

  assign psum = 10'(phase_v) + RAMP_STEP;

  // --------------------------------------------------------------------------
  // Effect update
  // --------------------------------------------------------------------------
  always_comb begin
    have_d    = have_q;
    cur_d     = cur_q;
    st_run_d  = st_run_q;
    st_lit_d  = st_lit_q;
    st_cnt_d  = st_cnt_q;
    st_last_d = st_last_q;
    ch_run_d  = ch_run_q;
    ch_lit_d  = ch_lit_q;
    ch_cnt_d  = ch_cnt_q;
    ch_last_d = ch_last_q;
    boost_d   = boost_q;
    phase_d   = phase_q;
    ra_last_d = ra_last_q;
    si_blue_d = si_blue_q;
    si_last_d = si_last_q;
    colour_d  = colour_q;
    wrote_d   = wrote_q;
    sts_o     = '0;

    if (cmd_i.eval) begin
      have_d  = 1'b1;
      cur_d   = prof_q;
      wrote_d = 1'b0;
      if (chg) begin
        ch_run_d  = 1'b1;
        ch_lit_d  = 1'b0;
        ch_cnt_d  = 8'd0;
        ch_last_d = now_q;
        boost_d   = 1'b0;
        phase_d   = 9'd0;
        si_blue_d = 1'b0;
        si_last_d = '0;
        colour_d  = RGB_OFF;
        wrote_d   = 1'b1;
      end

      if (st_run_q) begin
        if (el_st) begin
          st_last_d = now_q;
          st_lit_d  = !st_lit_q;
          wrote_d   = 1'b1;
          if (!st_lit_q) begin
            colour_d = profile_rgb(prof_q);
            if (st_cnt_q != 2'd3) begin
              st_cnt_d = st_cnt_q + 2'd1;
            end
          end else begin
            colour_d = RGB_OFF;
          end
          // done after the second blink has gone dark
          if (st_cnt_d >= 2'd2 && st_lit_q) begin
            st_run_d = 1'b0;
            colour_d = RGB_OFF;
          end
        end
      end else if (ch_run_d) begin
        if (el_ch) begin
          ch_last_d = now_q;
          ch_lit_d  = !ch_lit_v;
          wrote_d   = 1'b1;
          if (!ch_lit_v) begin
            colour_d = profile_rgb(prof_q);
            if (ch_cnt_v != 8'd255) begin
              ch_cnt_d = ch_cnt_v + 8'd1;
            end
          end else begin
            colour_d = RGB_OFF;
          end
          if (ch_cnt_d >= blinks_q && ch_lit_v) begin
            ch_run_d = 1'b0;
            colour_d = RGB_OFF;
          end
        end
      end else if (!turbo_q) begin
        if (boost_v) begin
          boost_d   = 1'b0;
          phase_d   = 9'd0;
          si_blue_d = 1'b0;
          colour_d  = RGB_OFF;
          wrote_d   = 1'b1;
        end
      end else if (prof_q == PROF_POLICE) begin
        if (el_si) begin
          si_last_d = now_q;
          boost_d   = 1'b1;
          si_blue_d = !si_blue_v;
          colour_d  = si_blue_v ? RGB_RED : RGB_BLUE;
          wrote_d   = 1'b1;
        end
      end else begin
        if (el_ra) begin
          ra_last_d     = now_q;
          boost_d       = 1'b1;
          phase_d       = (psum >= RAMP_WRAP) ? 9'd0 : psum[8:0];
          sts_o.ramp_go = 1'b1;
        end
      end
    end

    if (cmd_i.ramp_div) begin
      colour_d = {div255(pr_q), div255(pg_q), div255(pb_q)};
      wrote_d  = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Color ramp pipeline on phase_q
  // --------------------------------------------------------------------------
  logic [7:0]  lum_dist;
  logic [20:0] mul_g;
  logic [22:0] mul_l;
  logic [6:0]  q7;
  logic [13:0] xg, rem_g;
  logic [15:0] xl, rem_l;
  logic [6:0]  gdiv;
  logic [7:0]  ldiv, dbl, r5, lum_c, r_c, g_c, b_c;
  logic [2:0]  tens;
  logic        low_half;

  assign low_half = phase_q < 9'd255;
  assign lum_dist = low_half ? phase_q[7:0] : 8'(phase_q - 9'd255);
  assign q7       = phase_q[6:0];
  assign mul_g    = 21'(q7) * G_RECIP;
  assign mul_l    = 23'(lum_dist) * L_RECIP;

  assign xg    = 14'(q7) * 14'd80;
  assign rem_g = xg - (14'({est_g_q, 7'b0}) - 14'(est_g_q));
  assign gdiv  = est_g_q + 7'(rem_g >= 14'd127);
  assign xl    = 16'(lum_dist) * 16'd175;
  assign rem_l = xl - (16'({est_l_q, 8'b0}) - 16'({est_l_q, 1'b0}));
  assign ldiv  = est_l_q + 8'(rem_l >= 16'd254);
  assign lum_c = low_half ? 8'd80 + ldiv : 8'd255 - ldiv;

  // 255*q/127 = 2q + (q == 127); 255*q/125 = 2q + q/25
  assign dbl  = {q7, 1'b0} + 8'(q7 == 7'd127);
  assign tens = 3'(q7 >= 7'd25) + 3'(q7 >= 7'd50) + 3'(q7 >= 7'd75) + 3'(q7 >= 7'd100);
  assign r5   = {q7, 1'b0} + 8'(tens);

  always_comb begin
    case (phase_q[8:7])
      2'd0: begin
        r_c = 8'd255;
        g_c = 8'd80 - 8'(gdiv);
        b_c = 8'd0;
      end
      2'd1: begin
        r_c = 8'd255;
        g_c = 8'd0;
        b_c = dbl;
      end
      2'd2: begin
        r_c = 8'd255 - dbl;
        g_c = 8'd0;
        b_c = 8'd255;
      end
      default: begin
        r_c = r5;
        g_c = 8'd0;
        b_c = 8'd255 - r5;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      startup_iv_q <= STARTUP_IV_RST;
      profile_iv_q <= PROFILE_IV_RST;
      blinks_q     <= BLINKS_RST;
      frame_q      <= FRAME_RST;
      police_iv_q  <= POLICE_IV_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STARTUP_IV: startup_iv_q <= cfg_wdata_i;
        CFG_PROFILE_IV: profile_iv_q <= cfg_wdata_i;
        CFG_BLINKS:     blinks_q     <= cfg_wdata_i[7:0];
        CFG_FRAME:      frame_q      <= cfg_wdata_i;
        CFG_POLICE_IV:  police_iv_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q    <= 1'b0;
      cur_q     <= 3'd0;
      st_run_q  <= 1'b1;
      st_lit_q  <= 1'b0;
      st_cnt_q  <= 2'd0;
      st_last_q <= '0;
      ch_run_q  <= 1'b0;
      ch_lit_q  <= 1'b0;
      ch_cnt_q  <= 8'd0;
      ch_last_q <= '0;
      boost_q   <= 1'b0;
      phase_q   <= 9'd0;
      ra_last_q <= '0;
      si_blue_q <= 1'b0;
      si_last_q <= '0;
      colour_q  <= RGB_OFF;
      wrote_q   <= 1'b0;
    end else begin
      have_q    <= have_d;
      cur_q     <= cur_d;
      st_run_q  <= st_run_d;
      st_lit_q  <= st_lit_d;
      st_cnt_q  <= st_cnt_d;
      st_last_q <= st_last_d;
      ch_run_q  <= ch_run_d;
      ch_lit_q  <= ch_lit_d;
      ch_cnt_q  <= ch_cnt_d;
      ch_last_q <= ch_last_d;
      boost_q   <= boost_d;
      phase_q   <= phase_d;
      ra_last_q <= ra_last_d;
      si_blue_q <= si_blue_d;
      si_last_q <= si_last_d;
      colour_q  <= colour_d;
      wrote_q   <= wrote_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      now_q   <= TIME_BITS'(now_ms_i);
      prof_q  <= profile_i;
      turbo_q <= turbo_on_i;
    end
    if (cmd_i.ramp_est) begin
      est_g_q <= mul_g[20:14];
      est_l_q <= mul_l[22:15];
    end
    if (cmd_i.ramp_fix) begin
      r0_q  <= r_c;
      g0_q  <= g_c;
      b0_q  <= b_c;
      lum_q <= lum_c;
    end
    if (cmd_i.ramp_mul) begin
      pr_q <= 16'(r0_q) * 16'(lum_q);
      pg_q <= 16'(g0_q) * 16'(lum_q);
      pb_q <= 16'(b0_q) * 16'(lum_q);
    end
    if (cmd_i.load_out) begin
      out_write_q <= wrote_q;
      out_rgb_q   <= colour_q;
    end
  end

  assign led_write_o = out_write_q;
  assign led_red_o   = out_rgb_q[23:16];
  assign led_green_o = out_rgb_q[15:8];
  assign led_blue_o  = out_rgb_q[7:0];

endmodule

### hdl/status_led_effect_sequencer.sv
// ----------------------------------------------------------------------------
// status_led_effect_sequencer
// Startup blink, profile change blink, police and color ramp turbo effects
// for one RGB status LED; one result per input transfer.
// ----------------------------------------------------------------------------
// Sequence: an item is captured, the effect update runs, and the result is
//   loaded into the output register once that is free; on a color ramp step
//   four pipeline steps for the divides and the brightness scale come between.
// Flow: the controller works on one item at a time, and the output register
//   holds a result while the next item is taken.
// Reset: asynchronous, active low; configuration returns to its defaults and
//   the startup blink is armed with the LED off.
module status_led_effect_sequencer
  import sles_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // now_ms[31:0], profile[34:32], turbo_on[35], zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // led_write[0], led_red[8:1], led_green[16:9],
                                     // led_blue[24:17], zero
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  sles_cmd_t  cmd;
  sles_sts_t  sts;
  logic       led_write;
  logic [7:0] led_red, led_green, led_blue;

  sles_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  sles_datapath #(
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .now_ms_i    (s_axis_tdata[31:0]),
    .profile_i   (s_axis_tdata[34:32]),
    .turbo_on_i  (s_axis_tdata[35]),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .led_write_o (led_write),
    .led_red_o   (led_red),
    .led_green_o (led_green),
    .led_blue_o  (led_blue)
  );

  assign m_axis_tdata = {7'd0, led_blue, led_green, led_red, led_write};

endmodule

### hdl/sles_checker.sv
// ----------------------------------------------------------------------------
// sles_checker
// Port-level checks of the status LED effect sequencer, bound to the top.
// ----------------------------------------------------------------------------
module sles_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // one item at a time: busy right after an input transfer
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while previous item in progress");

  // no early result: none before the item is evaluated and loaded
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid ##1 !m_axis_tvalid)
    else $error("result appeared too early");

endmodule

bind status_led_effect_sequencer sles_checker u_sles_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
